// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, masked while reset is asserted.
`define AB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define AB_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/abfp_pkg.sv
`default_nettype none

package abfp_pkg;

    // Fixed point format of the feedback word
    localparam int FRAC_BITS     = 14;
    localparam int LSB_ZERO_BITS = 4;

    // Field and register widths
    localparam int NOM_W   = 10;
    localparam int CAP_W   = 16;
    localparam int TI_W    = 11;
    localparam int KP_W    = 16;
    localparam int FILL_W  = 16;
    localparam int OUT_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Internal arithmetic widths
    localparam int ERR_W    = FILL_W + 1;
    localparam int INTEG_W  = TI_W + FRAC_BITS;
    localparam int PDIV_W   = FILL_W + FRAC_BITS;
    localparam int DIVD_W   = (PDIV_W > INTEG_W - 1) ? PDIV_W : INTEG_W - 1;
    localparam int DIVS_W   = (KP_W > TI_W) ? KP_W : TI_W;
    localparam int CNT_W    = $clog2(DIVD_W);
    localparam int SUM_W    = DIVD_W + 2;
    localparam int CORR_W   = FRAC_BITS + 1;
    localparam int NOMFIX_W = NOM_W + FRAC_BITS;
    localparam int FIN_W    = NOMFIX_W + 2;

    // Constants
    localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MASK = ~OUT_W'((2 ** LSB_ZERO_BITS) - 1);
    localparam logic signed [CORR_W-1:0] HALF_CORR = CORR_W'(2 ** (FRAC_BITS - 1));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP     = 2'd3;

    // Register reset values
    localparam logic [NOM_W-1:0] NOMINAL_RST  = NOM_W'(48);
    localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(1024);
    localparam logic [TI_W-1:0]  INTEG_RST    = TI_W'(16);
    localparam logic [KP_W-1:0]  PROP_RST     = KP_W'(256);

    // Request into the shared divider
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

// File: rtl/abfp_div.sv
`default_nettype none
`include "assert_macros.svh"

// Restoring unsigned divider, one quotient bit per cycle.
module abfp_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire abfp_pkg::div_req_t       req,
    output logic                          done,
    output logic [abfp_pkg::DIVD_W-1:0]   quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [abfp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [abfp_pkg::DIVD_W-1:0]   quo_reg, quo_next;
    logic [abfp_pkg::DIVS_W-1:0]   rem_reg, rem_next;
    logic [abfp_pkg::DIVS_W-1:0]   dvs_reg, dvs_next;

    logic [abfp_pkg::DIVS_W:0]     shifted;
    logic [abfp_pkg::DIVS_W:0]     diff;
    logic                          fits;

    // One trial subtraction
    assign shifted = {rem_reg, quo_reg[abfp_pkg::DIVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = !diff[abfp_pkg::DIVS_W];

    // Sequencing of the iterations
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = abfp_pkg::CNT_W'(abfp_pkg::DIVD_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[abfp_pkg::DIVD_W-2:0], fits};
            rem_next = fits ? diff[abfp_pkg::DIVS_W-1:0] : shifted[abfp_pkg::DIVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `AB_ASSERT(a_start_idle, aclk, aresetn, req.start |-> !busy_reg, "divider restarted while busy")
    `AB_ASSERT(a_rem_range, aclk, aresetn, done_reg |-> (rem_reg < dvs_reg), "remainder not below divisor")
    `AB_ASSERT(a_start_load, aclk, aresetn, req.start |=> (busy_reg && cnt_reg == abfp_pkg::CNT_W'(abfp_pkg::DIVD_W - 1)), "divider did not load")

endmodule

`default_nettype wire

// File: rtl/audio_buffer_feedback_pi.sv
// PI regulator for the asynchronous audio feedback word. Each s_ transfer carries the ring
// fill level (s_tdata) and an action flag (s_tuser: 0 = update, 1 = restart); each yields
// exactly one m_ transfer with the 24-bit feedback value (14 fraction bits, low 4 bits cleared
// after an update). In an update both trunc-toward-zero quotients (proportional term, integral
// term) run one after the other through a single restoring divider that produces one quotient
// bit per cycle. s_tready is high only while the regulator is idle; a finished result sits in
// the output register, so the next item can be taken while it waits. Registers are written over
// the cfg_ port (always ready); the user must write them only while no item is in flight, as
// the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module audio_buffer_feedback_pi (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [abfp_pkg::FILL_W-1:0]     s_tdata,   // [15:0] fill_level
    input  wire logic [0:0]                      s_tuser,   // [0] action
    // Result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [abfp_pkg::OUT_W-1:0]           m_tdata,   // [23:0] feedback_value
    // Register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [abfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [abfp_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_INTEG = 7'b0000010,
        ST_DIVP  = 7'b0000100,
        ST_DIVI  = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [abfp_pkg::NOM_W-1:0] nominal_reg;
    logic [abfp_pkg::CAP_W-1:0] capacity_reg;
    logic [abfp_pkg::TI_W-1:0]  integ_time_reg;
    logic [abfp_pkg::KP_W-1:0]  prop_reg;

    logic signed [abfp_pkg::ERR_W-1:0]   err_reg, err_next;
    logic signed [abfp_pkg::INTEG_W-1:0] integ_reg, integ_next;
    logic signed [abfp_pkg::DIVD_W:0]    qp_reg, qp_next;
    logic signed [abfp_pkg::DIVD_W:0]    qi_reg, qi_next;
    logic signed [abfp_pkg::CORR_W-1:0]  corr_reg, corr_next;
    logic [abfp_pkg::OUT_W-1:0]          res_reg, res_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [abfp_pkg::OUT_W-1:0]          m_tdata_reg, m_tdata_next;

    logic [abfp_pkg::KP_W-1:0]           kp;
    logic [abfp_pkg::TI_W-1:0]           ti;
    logic signed [abfp_pkg::INTEG_W-1:0] limit_s, neg_limit;
    logic signed [abfp_pkg::ERR_W-1:0]   err_new, neg_err;
    logic signed [abfp_pkg::INTEG_W:0]   isum;
    logic signed [abfp_pkg::INTEG_W-1:0] neg_integ;
    logic [abfp_pkg::FILL_W-1:0]         err_mag;
    logic [abfp_pkg::INTEG_W-2:0]        integ_mag;
    logic signed [abfp_pkg::DIVD_W:0]    q_pos;
    logic signed [abfp_pkg::SUM_W-1:0]   corr_sum;
    logic [abfp_pkg::NOMFIX_W-1:0]       nom_fix;
    logic [abfp_pkg::OUT_W-1:0]          nom_out;
    logic signed [abfp_pkg::FIN_W-1:0]   fin;
    logic [abfp_pkg::OUT_W-1:0]          fin_sat;
    logic                                s_xfer, m_free;

    abfp_pkg::div_req_t                  div_req;
    logic                                div_done;
    logic [abfp_pkg::DIVD_W-1:0]         div_quo;

    abfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_free    = !m_tvalid_reg || m_tready;

    // Divisors, zero acts as one
    assign kp = (prop_reg == '0) ? abfp_pkg::KP_W'(1) : prop_reg;
    assign ti = (integ_time_reg == '0) ? abfp_pkg::TI_W'(1) : integ_time_reg;

    // Integrator limit = ti * 2^(FRAC_BITS-1)
    assign limit_s   = $signed({1'b0, ti, {(abfp_pkg::FRAC_BITS - 1){1'b0}}});
    assign neg_limit = -limit_s;

    // Set point minus fill
    assign err_new = $signed({2'b00, capacity_reg[abfp_pkg::CAP_W-1:1]})
                   - $signed({1'b0, s_tdata});

    // Integrator update with clamp
    assign isum = (abfp_pkg::INTEG_W + 1)'(integ_reg) + (abfp_pkg::INTEG_W + 1)'(err_reg);

    // Magnitudes into the unsigned divider
    assign neg_err   = -err_reg;
    assign err_mag   = err_reg[abfp_pkg::ERR_W-1] ? neg_err[abfp_pkg::FILL_W-1:0]
                                                  : err_reg[abfp_pkg::FILL_W-1:0];
    assign neg_integ = -integ_reg;
    assign integ_mag = integ_reg[abfp_pkg::INTEG_W-1] ? neg_integ[abfp_pkg::INTEG_W-2:0]
                                                      : integ_reg[abfp_pkg::INTEG_W-2:0];
    assign q_pos     = $signed({1'b0, div_quo});

    // Correction sum
    assign corr_sum = abfp_pkg::SUM_W'(qp_reg) + abfp_pkg::SUM_W'(qi_reg);

    // Nominal in fixed point, and final output with saturation
    assign nom_fix = {nominal_reg, {abfp_pkg::FRAC_BITS{1'b0}}};
    assign nom_out = (nom_fix > abfp_pkg::OUT_MAX) ? abfp_pkg::OUT_MAX
                                                   : abfp_pkg::OUT_W'(nom_fix);
    assign fin     = $signed({2'b00, nom_fix}) + abfp_pkg::FIN_W'(corr_reg);

    always_comb begin
        if (fin[abfp_pkg::FIN_W-1]) begin
            fin_sat = '0;
        end else if ({1'b0, fin[abfp_pkg::FIN_W-2:0]} > abfp_pkg::OUT_MAX) begin
            fin_sat = abfp_pkg::OUT_MAX;
        end else begin
            fin_sat = abfp_pkg::OUT_W'(fin[abfp_pkg::FIN_W-2:0]);
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        err_next      = err_reg;
        integ_next    = integ_reg;
        qp_next       = qp_reg;
        qi_next       = qi_reg;
        corr_next     = corr_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        div_req.start    = 1'b0;
        div_req.dividend = abfp_pkg::DIVD_W'({err_mag, {abfp_pkg::FRAC_BITS{1'b0}}});
        div_req.divisor  = abfp_pkg::DIVS_W'(kp);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser[0]) begin
                        integ_next = '0;
                        res_next   = nom_out;
                        state_next = ST_EMIT;
                    end else begin
                        err_next   = err_new;
                        state_next = ST_INTEG;
                    end
                end
            end
            ST_INTEG: begin
                if (isum > (abfp_pkg::INTEG_W + 1)'(limit_s)) begin
                    integ_next = limit_s;
                end else if (isum < (abfp_pkg::INTEG_W + 1)'(neg_limit)) begin
                    integ_next = neg_limit;
                end else begin
                    integ_next = isum[abfp_pkg::INTEG_W-1:0];
                end
                div_req.start = 1'b1;
                state_next    = ST_DIVP;
            end
            ST_DIVP: begin
                div_req.dividend = abfp_pkg::DIVD_W'(integ_mag);
                div_req.divisor  = abfp_pkg::DIVS_W'(ti);
                if (div_done) begin
                    qp_next       = err_reg[abfp_pkg::ERR_W-1] ? -q_pos : q_pos;
                    div_req.start = 1'b1;
                    state_next    = ST_DIVI;
                end
            end
            ST_DIVI: begin
                if (div_done) begin
                    qi_next    = integ_reg[abfp_pkg::INTEG_W-1] ? -q_pos : q_pos;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (corr_sum > abfp_pkg::SUM_W'(abfp_pkg::HALF_CORR)) begin
                    corr_next = abfp_pkg::HALF_CORR;
                end else if (corr_sum < -abfp_pkg::SUM_W'(abfp_pkg::HALF_CORR)) begin
                    corr_next = -abfp_pkg::HALF_CORR;
                end else begin
                    corr_next = corr_sum[abfp_pkg::CORR_W-1:0];
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                res_next   = fin_sat & abfp_pkg::OUT_MASK;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and integrator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            integ_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            integ_reg    <= integ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        err_reg     <= err_next;
        qp_reg      <= qp_next;
        qi_reg      <= qi_next;
        corr_reg    <= corr_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg    <= abfp_pkg::NOMINAL_RST;
            capacity_reg   <= abfp_pkg::CAPACITY_RST;
            integ_time_reg <= abfp_pkg::INTEG_RST;
            prop_reg       <= abfp_pkg::PROP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                abfp_pkg::REG_NOMINAL:  nominal_reg    <= cfg_data[abfp_pkg::NOM_W-1:0];
                abfp_pkg::REG_CAPACITY: capacity_reg   <= cfg_data[abfp_pkg::CAP_W-1:0];
                abfp_pkg::REG_INTEG:    integ_time_reg <= cfg_data[abfp_pkg::TI_W-1:0];
                abfp_pkg::REG_PROP:     prop_reg       <= cfg_data[abfp_pkg::KP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `AB_ASSERT(a_integ_lim, aclk, aresetn, (state_reg == ST_DIVP) |-> (integ_reg <= limit_s && integ_reg >= neg_limit), "integrator outside limit")
    `AB_ASSERT(a_corr_lim, aclk, aresetn, (state_reg == ST_FIN) |-> (corr_reg <= abfp_pkg::HALF_CORR && corr_reg >= -abfp_pkg::HALF_CORR), "correction outside half sample")
    `AB_ASSERT(a_div_phase, aclk, aresetn, div_done |-> (state_reg == ST_DIVP || state_reg == ST_DIVI), "divider result outside divide phase")
    `AB_ASSERT(a_restart, aclk, aresetn, (s_xfer && s_tuser[0]) |=> (state_reg == ST_EMIT && integ_reg == '0), "restart did not clear integrator")

endmodule

`default_nettype wire
